@@ sv/buddy_page_allocator_assert.svh @@
// Assertion macros for the allocator module.
`ifndef BUDDY_PAGE_ALLOCATOR_ASSERT_SVH
`define BUDDY_PAGE_ALLOCATOR_ASSERT_SVH
`define BPA_ASSERT_NOW(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("buddy allocator assertion failed");
`define BPA_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("buddy allocator assertion failed");
`endif

@@ sv/bpa_pkg.sv @@
package bpa_pkg;

  localparam int ORD_W = 6;
  localparam int CNT_ORD_W = 5;

  typedef enum logic [1:0] {
    CFG_TOTAL  = 2'd0,
    CFG_BASE   = 2'd1,
    CFG_PAGES  = 2'd2,
    CFG_UNUSED = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_FEW   = 3'd1,
    ST_BIG   = 3'd2,
    ST_NOBLK = 3'd3,
    ST_ZERO  = 3'd4
  } status_e;

  typedef enum logic [4:0] {
    S_CLR, S_RB, S_IDLE, S_DEC, S_SRCH, S_ALOOP, S_ASPLIT, S_AP1, S_AP2, S_ARED,
    S_ANEXT, S_ATAKE, S_FRED, S_FUL, S_FMRG, S_FMCK, S_FMUP, S_FPUSH, S_FIN,
    S_ULRD, S_ULEX, S_PURD, S_PUCK, S_PUWR, S_PULK
  } state_e;

  typedef struct packed {
    logic                 clr;
    logic                 add;
    logic                 sub;
    logic [CNT_ORD_W-1:0] ord;
  } cnt_op_t;

  function automatic logic [ORD_W-1:0] ceil_order(input logic [31:0] n);
    logic [ORD_W-1:0] o;
    o = ORD_W'(32);
    for (int i = 32; i >= 0; i--) begin
      if ((33'(1) << i) >= {1'b0, n}) begin
        o = ORD_W'(i);
      end
    end
    return o;
  endfunction

  function automatic logic [CNT_ORD_W-1:0] floor_order(input logic [15:0] v);
    logic [CNT_ORD_W-1:0] o;
    o = '0;
    for (int i = 0; i < 16; i++) begin
      if (v >= (16'(1) << i)) begin
        o = CNT_ORD_W'(i);
      end
    end
    return o;
  endfunction

endpackage

@@ sv/buddy_page_allocator.sv @@
// One item is handled at a time: input stays stalled until its result is placed in the output
// register, which waits while out_stall_i holds back the last result. The sequencer shares one
// read port of the page memories.
// Reset or a write to the total, base or page-count register runs a clearing pass over the page
// memories, then places the region block if the page count is nonzero; input stays stalled
// meanwhile, register writes are always taken.
`include "buddy_page_allocator_assert.svh"
module buddy_page_allocator #(
  parameter int MAX_ORDER_P   = 15,
  parameter int PAGE_CAPACITY = 32768
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        req_type_i,
  input  logic [31:0] page_count_i,
  input  logic [14:0] page_index_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [14:0] alloc_index_o,
  output logic [15:0] free_pages_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  import bpa_pkg::*;

  localparam int AW  = (PAGE_CAPACITY > 1) ? $clog2(PAGE_CAPACITY) : 1;
  localparam int OW  = (MAX_ORDER_P > 0) ? $clog2(MAX_ORDER_P + 1) : 1;
  localparam int MW  = OW + 1;
  localparam int CW  = (AW + MAX_ORDER_P + 1 > 17) ? AW + MAX_ORDER_P + 1 : 17;
  localparam int WM  = (AW > MAX_ORDER_P) ? AW : MAX_ORDER_P;
  localparam int WW  = ((WM > 16) ? WM : 16) + 2;
  localparam logic [WW-1:0]    CAP_W = WW'(PAGE_CAPACITY);
  localparam logic [ORD_W-1:0] MAXO  = ORD_W'(MAX_ORDER_P);
  localparam logic [AW:0]      NIL   = {1'b1, {AW{1'b0}}};
  localparam logic [AW-1:0]    LAST  = AW'(PAGE_CAPACITY - 1);

  state_e            state_q, state_d, ret_q, ret_d;
  status_e           st_q, st_d;
  logic [15:0]       total_q, total_d, rpages_q, rpages_d;
  logic [14:0]       base_q, base_d, pidx_q, pidx_d;
  logic              req_q, req_d;
  logic [31:0]       n_q, n_d;
  logic [WW-1:0]     red_q, red_d;
  logic [AW-1:0]     ptr_q, ptr_d, cur_q, cur_d, b_q, b_d, h_q, h_d;
  logic [AW-1:0]     arg_q, arg_d, res_q, res_d;
  logic [AW:0]       hl_q, hl_d;
  logic [OW-1:0]     ord_q, ord_d;
  logic [ORD_W-1:0]  co_q, co_d, ro_q, ro_d, o_q, o_d;
  logic              out_valid_q, out_valid_d;
  logic [2:0]        out_status_q, out_status_d;
  logic [14:0]       out_index_q, out_index_d;
  logic [15:0]       out_free_q, out_free_d;

  logic [AW:0]       lh_q [MAX_ORDER_P+1];
  logic              lh_we, lh_clr;
  logic [OW-1:0]     lh_wa, lh_ra;
  logic [AW:0]       lh_wd, lh_rd;

  logic [AW-1:0]     raddr, meta_wa, nxt_wa, prv_wa;
  logic              meta_we, nxt_we, prv_we;
  logic [MW-1:0]     meta_wd, meta_rd;
  logic [AW:0]       nxt_wd, nxt_rd, prv_wd, prv_rd;
  logic              m_fh;
  logic [OW-1:0]     m_ord;

  cnt_op_t           cnt_op;
  logic [CW-1:0]     count;
  logic [15:0]       count_sat;

  logic              cfg_wr, few, ceil_big, red_ge, b_out;
  logic [ORD_W-1:0]  ceil_n, co_m1, rb_ord;
  logic [WW-1:0]     b_w, bound_w, half_w, res_w;

  bpa_ram #(.WIDTH(MW), .DEPTH(PAGE_CAPACITY)) u_meta (
    .clk_i, .we_i(meta_we), .waddr_i(meta_wa), .wdata_i(meta_wd),
    .raddr_i(raddr), .rdata_o(meta_rd)
  );
  bpa_ram #(.WIDTH(AW + 1), .DEPTH(PAGE_CAPACITY)) u_next (
    .clk_i, .we_i(nxt_we), .waddr_i(nxt_wa), .wdata_i(nxt_wd),
    .raddr_i(raddr), .rdata_o(nxt_rd)
  );
  bpa_ram #(.WIDTH(AW + 1), .DEPTH(PAGE_CAPACITY)) u_prev (
    .clk_i, .we_i(prv_we), .waddr_i(prv_wa), .wdata_i(prv_wd),
    .raddr_i(raddr), .rdata_o(prv_rd)
  );

  bpa_cnt #(.CW(CW)) u_cnt (
    .clk_i, .rst_ni, .op_i(cnt_op), .count_o(count), .sat_o(count_sat)
  );

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && (cfg_index_i != CFG_UNUSED);
  assign in_stall_o  = (state_q != S_IDLE);
  assign m_fh        = meta_rd[OW];
  assign m_ord       = meta_rd[OW-1:0];
  assign ceil_n      = ceil_order(n_q);
  assign ceil_big    = ceil_n > MAXO;
  assign few         = 64'(n_q) > 64'(count);
  assign red_ge      = red_q >= CAP_W;
  assign co_m1       = co_q - ORD_W'(1);
  assign half_w      = WW'(1) << co_m1;
  assign b_w         = WW'(cur_q) ^ (WW'(1) << o_q);
  assign bound_w     = (WW'(total_q) < CAP_W) ? WW'(total_q) : CAP_W;
  assign b_out       = (o_q >= MAXO) || (b_w >= bound_w);
  assign rb_ord      = (ORD_W'(floor_order(rpages_q)) > MAXO) ? MAXO
                       : ORD_W'(floor_order(rpages_q));
  assign res_w       = WW'(res_q);

  always_comb begin
    unique case (state_q)
      S_SRCH, S_ASPLIT: lh_ra = co_q[OW-1:0];
      S_ATAKE:          lh_ra = ro_q[OW-1:0];
      S_PUWR:           lh_ra = ord_q;
      default:          lh_ra = '0;
    endcase
  end
  assign lh_rd = lh_q[lh_ra];
  assign raddr = (state_q == S_FMRG) ? b_w[AW-1:0] : arg_q;

  always_comb begin
    state_d = state_q;
    if (cfg_wr) begin
      state_d = S_CLR;
    end else begin
      unique case (state_q)
        S_CLR:    if (ptr_q == LAST && !red_ge) state_d = S_RB;
        S_RB:     state_d = (rpages_q == '0) ? S_IDLE : S_PURD;
        S_IDLE:   if (in_valid_i) state_d = S_DEC;
        S_DEC: begin
          if (n_q == '0) begin
            state_d = S_FIN;
          end else if (req_q) begin
            state_d = S_FRED;
          end else if (few || ceil_big) begin
            state_d = S_FIN;
          end else begin
            state_d = S_SRCH;
          end
        end
        S_SRCH: begin
          if (co_q > MAXO) begin
            state_d = S_FIN;
          end else if (!lh_rd[AW]) begin
            state_d = S_ALOOP;
          end
        end
        S_ALOOP:  state_d = (co_q > ro_q) ? S_ASPLIT : S_ATAKE;
        S_ASPLIT: state_d = S_ULRD;
        S_AP1:    state_d = S_PURD;
        S_AP2:    state_d = S_ARED;
        S_ARED:   if (!red_ge) state_d = S_PURD;
        S_ANEXT:  state_d = S_ALOOP;
        S_ATAKE:  state_d = S_ULRD;
        S_FRED:   if (!red_ge) state_d = S_FUL;
        S_FUL:    state_d = S_ULRD;
        S_FMRG:   state_d = b_out ? S_FPUSH : S_FMCK;
        S_FMCK:   state_d = (!m_fh || m_ord != o_q[OW-1:0]) ? S_FPUSH : S_ULRD;
        S_FMUP:   state_d = S_FMRG;
        S_FPUSH:  state_d = S_PURD;
        S_FIN:    if (!out_valid_q || !out_stall_i) state_d = S_IDLE;
        S_ULRD:   state_d = S_ULEX;
        S_ULEX:   state_d = ret_q;
        S_PURD:   state_d = S_PUCK;
        S_PUCK:   state_d = S_PUWR;
        S_PUWR:   state_d = S_PULK;
        S_PULK:   state_d = ret_q;
        default:  state_d = S_CLR;
      endcase
    end
  end

  always_comb begin
    ret_d = ret_q;  st_d = st_q;  total_d = total_q;  base_d = base_q;
    rpages_d = rpages_q;  req_d = req_q;  n_d = n_q;  pidx_d = pidx_q;
    red_d = red_q;  ptr_d = ptr_q;  cur_d = cur_q;  b_d = b_q;  h_d = h_q;
    arg_d = arg_q;  res_d = res_q;  hl_d = hl_q;  ord_d = ord_q;
    co_d = co_q;  ro_d = ro_q;  o_d = o_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_status_d = out_status_q;
    out_index_d  = out_index_q;
    out_free_d   = out_free_q;
    lh_we = 1'b0;  lh_clr = 1'b0;  lh_wa = '0;  lh_wd = NIL;
    meta_we = 1'b0;  meta_wa = arg_q;  meta_wd = '0;
    nxt_we = 1'b0;  nxt_wa = arg_q;  nxt_wd = NIL;
    prv_we = 1'b0;  prv_wa = arg_q;  prv_wd = NIL;
    cnt_op = '0;

    if (cfg_wr) begin
      unique case (cfg_index_i)
        CFG_TOTAL: total_d  = cfg_data_i;
        CFG_BASE:  base_d   = cfg_data_i[14:0];
        CFG_PAGES: rpages_d = cfg_data_i;
        default:   total_d  = total_q;
      endcase
      ptr_d      = '0;
      red_d      = (cfg_index_i == CFG_BASE) ? WW'(cfg_data_i[14:0]) : WW'(base_q);
      lh_clr     = 1'b1;
      cnt_op.clr = 1'b1;
    end else begin
      unique case (state_q)
        S_CLR: begin
          meta_we = 1'b1;  meta_wa = ptr_q;
          nxt_we  = 1'b1;  nxt_wa  = ptr_q;
          prv_we  = 1'b1;  prv_wa  = ptr_q;
          if (ptr_q != LAST) ptr_d = ptr_q + AW'(1);
          if (red_ge) red_d = red_q - CAP_W;
        end
        S_RB: begin
          arg_d = red_q[AW-1:0];
          ord_d = rb_ord[OW-1:0];
          ret_d = S_IDLE;
        end
        S_IDLE: begin
          req_d  = req_type_i;
          n_d    = page_count_i;
          pidx_d = page_index_i;
        end
        S_DEC: begin
          res_d = '0;
          st_d  = ST_OK;
          if (n_q == '0) begin
            st_d = ST_ZERO;
          end else if (req_q) begin
            red_d = WW'(pidx_q);
            o_d   = ceil_big ? MAXO : ceil_n;
          end else if (few) begin
            st_d = ST_FEW;
          end else if (ceil_big) begin
            st_d = ST_BIG;
          end else begin
            ro_d = ceil_n;
            co_d = ceil_n;
          end
        end
        S_SRCH: begin
          if (co_q > MAXO) begin
            st_d = ST_NOBLK;
          end else if (lh_rd[AW]) begin
            co_d = co_q + ORD_W'(1);
          end
        end
        S_ASPLIT: begin
          h_d   = lh_rd[AW-1:0];
          arg_d = lh_rd[AW-1:0];
          ret_d = S_AP1;
        end
        S_AP1: begin
          arg_d = h_q;
          ord_d = co_m1[OW-1:0];
          ret_d = S_AP2;
        end
        S_AP2:   red_d = WW'(h_q) + half_w;
        S_ARED: begin
          if (red_ge) begin
            red_d = red_q - CAP_W;
          end else begin
            arg_d = red_q[AW-1:0];
            ord_d = co_m1[OW-1:0];
            ret_d = S_ANEXT;
          end
        end
        S_ANEXT: co_d = co_m1;
        S_ATAKE: begin
          res_d = lh_rd[AW-1:0];
          arg_d = lh_rd[AW-1:0];
          ret_d = S_FIN;
        end
        S_FRED: begin
          if (red_ge) begin
            red_d = red_q - CAP_W;
          end else begin
            cur_d = red_q[AW-1:0];
          end
        end
        S_FUL: begin
          arg_d = cur_q;
          ret_d = S_FMRG;
        end
        S_FMRG:  b_d = b_w[AW-1:0];
        S_FMCK: begin
          arg_d = b_q;
          ret_d = S_FMUP;
        end
        S_FMUP: begin
          if (b_q < cur_q) cur_d = b_q;
          o_d = o_q + ORD_W'(1);
        end
        S_FPUSH: begin
          arg_d = cur_q;
          ord_d = o_q[OW-1:0];
          ret_d = S_FIN;
        end
        S_FIN: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_d  = 1'b1;
            out_status_d = st_q;
            out_index_d  = res_w[14:0];
            out_free_d   = count_sat;
          end
        end
        S_ULEX, S_PUCK: begin
          if (m_fh) begin
            if (prv_rd[AW]) begin
              lh_we = 1'b1;  lh_wa = m_ord;  lh_wd = nxt_rd;
            end else begin
              nxt_we = 1'b1;  nxt_wa = prv_rd[AW-1:0];  nxt_wd = nxt_rd;
            end
            if (!nxt_rd[AW]) begin
              prv_we = 1'b1;  prv_wa = nxt_rd[AW-1:0];  prv_wd = prv_rd;
            end
            meta_we    = 1'b1;
            meta_wd    = {1'b0, m_ord};
            cnt_op.sub = 1'b1;
            cnt_op.ord = CNT_ORD_W'(m_ord);
          end
        end
        S_PUWR: begin
          meta_we    = 1'b1;  meta_wd = {1'b1, ord_q};
          nxt_we     = 1'b1;  nxt_wd  = lh_rd;
          prv_we     = 1'b1;  prv_wd  = NIL;
          lh_we      = 1'b1;  lh_wa   = ord_q;  lh_wd = {1'b0, arg_q};
          cnt_op.add = 1'b1;
          cnt_op.ord = CNT_ORD_W'(ord_q);
          hl_d       = lh_rd;
        end
        S_PULK: begin
          if (!hl_q[AW]) begin
            prv_we = 1'b1;  prv_wa = hl_q[AW-1:0];  prv_wd = {1'b0, arg_q};
          end
        end
        default: ptr_d = ptr_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      ret_q       <= S_IDLE;
      total_q     <= 16'h8000;
      base_q      <= '0;
      rpages_q    <= 16'h8000;
      red_q       <= '0;
      ptr_q       <= '0;
      out_valid_q <= 1'b0;
      co_q        <= '0;
      ro_q        <= '0;
      o_q         <= '0;
      for (int i = 0; i <= MAX_ORDER_P; i++) lh_q[i] <= NIL;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      total_q     <= total_d;
      base_q      <= base_d;
      rpages_q    <= rpages_d;
      red_q       <= red_d;
      ptr_q       <= ptr_d;
      out_valid_q <= out_valid_d;
      co_q        <= co_d;
      ro_q        <= ro_d;
      o_q         <= o_d;
      if (lh_clr) begin
        for (int i = 0; i <= MAX_ORDER_P; i++) lh_q[i] <= NIL;
      end else if (lh_we) begin
        lh_q[lh_wa] <= lh_wd;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    st_q         <= st_d;
    req_q        <= req_d;
    n_q          <= n_d;
    pidx_q       <= pidx_d;
    cur_q        <= cur_d;
    b_q          <= b_d;
    h_q          <= h_d;
    arg_q        <= arg_d;
    res_q        <= res_d;
    hl_q         <= hl_d;
    ord_q        <= ord_d;
    out_status_q <= out_status_d;
    out_index_q  <= out_index_d;
    out_free_q   <= out_free_d;
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign alloc_index_o = out_index_q;
  assign free_pages_o  = out_free_q;

  `BPA_ASSERT_NEXT(a_accept_dec, clk_i, rst_ni, in_valid_i && !in_stall_o && !cfg_wr, state_q == S_DEC)
  `BPA_ASSERT_NEXT(a_fin_hold, clk_i, rst_ni, state_q == S_FIN && out_valid_q && out_stall_i && !cfg_wr, state_q == S_FIN)
  `BPA_ASSERT_NOW(a_split_head, clk_i, rst_ni, state_q == S_ASPLIT, co_q > ro_q && !lh_rd[AW])

endmodule

@@ sv/bpa_ram.sv @@
module bpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                         clk_i,
  input  logic                                         we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                             wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                             rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/bpa_cnt.sv @@
module bpa_cnt #(
  parameter int CW = 31
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bpa_pkg::cnt_op_t  op_i,
  output logic [CW-1:0]     count_o,
  output logic [15:0]       sat_o
);

  import bpa_pkg::*;

  logic [CW-1:0] count_q, count_d, delta;

  assign delta = CW'(1) << op_i.ord;

  always_comb begin
    priority if (op_i.clr) begin
      count_d = '0;
    end else if (op_i.add) begin
      count_d = count_q + delta;
    end else if (op_i.sub) begin
      count_d = count_q - delta;
    end else begin
      count_d = count_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign count_o = count_q;
  assign sat_o   = (count_q > CW'(16'hFFFF)) ? 16'hFFFF : count_q[15:0];

endmodule

@@ tb/buddy_page_allocator_tb.sv @@
module buddy_page_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bpa_pkg::*;

  localparam int PAGE_CAP = 32768;
  localparam int TOP_ORDER = 15;
  localparam logic [15:0] NO_LINK = 16'hFFFF;
  localparam longint CYCLE_LIMIT = 4000000;

  typedef struct {
    status_e     st;
    logic [14:0] idx;
    logic [15:0] fp;
  } answer_t;

  class alloc_scoreboard;
    logic [3:0]  ord_of [PAGE_CAP];
    bit          listed [PAGE_CAP];
    logic [15:0] nxt [PAGE_CAP];
    logic [15:0] prv [PAGE_CAP];
    logic [15:0] head [TOP_ORDER+1];
    longint unsigned free_total;
    logic [15:0] total_r;
    logic [14:0] base_r;
    logic [15:0] pages_r;
    answer_t pending[$];
    int errors;
    int checked;

    function new();
      total_r = 16'd32768;
      base_r = '0;
      pages_r = 16'd32768;
      errors = 0;
      checked = 0;
      rebuild();
    endfunction

    function void unlink(int p);
      logic [15:0] a;
      logic [15:0] b;
      a = prv[p];
      b = nxt[p];
      if (a == NO_LINK) head[ord_of[p]] = b;
      else nxt[a] = b;
      if (b != NO_LINK) prv[b] = a;
      prv[p] = NO_LINK;
      nxt[p] = NO_LINK;
      listed[p] = 0;
      free_total -= longint'(1) << ord_of[p];
    endfunction

    function void push(int p, int o);
      logic [15:0] h;
      if (listed[p]) unlink(p);
      h = head[o];
      ord_of[p] = 4'(o);
      prv[p] = NO_LINK;
      nxt[p] = h;
      if (h != NO_LINK) prv[h] = 16'(p);
      head[o] = 16'(p);
      listed[p] = 1;
      free_total += longint'(1) << o;
    endfunction

    function int ceil_ord(longint unsigned n);
      int o;
      o = 0;
      while ((longint'(1) << o) < n) o++;
      return o;
    endfunction

    function void rebuild();
      int o;
      for (int i = 0; i < PAGE_CAP; i++) begin
        ord_of[i] = '0;
        listed[i] = 0;
        nxt[i] = NO_LINK;
        prv[i] = NO_LINK;
      end
      for (int i = 0; i <= TOP_ORDER; i++) head[i] = NO_LINK;
      free_total = 0;
      if (pages_r != 0) begin
        o = 0;
        while (o < TOP_ORDER && (longint'(2) << o) <= pages_r) o++;
        push(int'(base_r) % PAGE_CAP, o);
      end
    endfunction

    function void write_reg(cfg_idx_e r, logic [15:0] v);
      case (r)
        CFG_TOTAL: total_r = v;
        CFG_BASE:  base_r = v[14:0];
        CFG_PAGES: pages_r = v;
        default:   return;
      endcase
      rebuild();
    endfunction

    function answer_t note_request(bit req, logic [31:0] cnt, logic [14:0] pidx);
      answer_t a;
      int ro;
      int co;
      int h;
      int o;
      int cur;
      int bnd;
      int bud;
      a.st = ST_OK;
      a.idx = '0;
      if (cnt == 0) begin
        a.st = ST_ZERO;
      end else if (req == 1'b0) begin
        ro = ceil_ord(cnt);
        if (longint'(cnt) > free_total) begin
          a.st = ST_FEW;
        end else if (ro > TOP_ORDER) begin
          a.st = ST_BIG;
        end else begin
          co = ro;
          while (co <= TOP_ORDER && head[co] == NO_LINK) co++;
          if (co > TOP_ORDER) begin
            a.st = ST_NOBLK;
          end else begin
            while (co > ro) begin
              h = head[co];
              unlink(h);
              push(h, co - 1);
              push((h + (1 << (co - 1))) % PAGE_CAP, co - 1);
              co--;
            end
            h = head[ro];
            unlink(h);
            a.idx = 15'(h);
          end
        end
      end else begin
        o = ceil_ord(cnt);
        if (o > TOP_ORDER) o = TOP_ORDER;
        cur = pidx;
        bnd = (total_r < PAGE_CAP) ? int'(total_r) : PAGE_CAP;
        if (listed[cur]) unlink(cur);
        while (o < TOP_ORDER) begin
          bud = cur ^ (1 << o);
          if (bud >= bnd) break;
          if (!listed[bud] || ord_of[bud] != o) break;
          unlink(bud);
          if (bud < cur) cur = bud;
          o++;
        end
        push(cur, o);
      end
      a.fp = (free_total > 64'hFFFF) ? 16'hFFFF : 16'(free_total);
      pending.push_back(a);
      return a;
    endfunction

    function void check_result(logic [2:0] st, logic [14:0] idx, logic [15:0] fp);
      answer_t e;
      checked++;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: status %0d index %0d free %0d",
                                   st, idx, fp);
        return;
      end
      e = pending.pop_front();
      if (st !== e.st || idx !== e.idx || fp !== e.fp) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected status %0d index %0d free %0d, got %0d %0d %0d",
                   e.st, e.idx, e.fp, st, idx, fp);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall_o;
  logic        req_type = 1'b0;
  logic [31:0] page_count = '0;
  logic [14:0] page_index = '0;
  logic        out_valid_o;
  logic        out_stall = 1'b0;
  logic [2:0]  status_o;
  logic [14:0] alloc_index_o;
  logic [15:0] free_pages_o;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  alloc_scoreboard sb = new();
  int held_idx[$];
  int held_cnt[$];
  int stall_mode = 0;
  int items_sent = 0;
  int allocs_ok = 0;
  longint cycles = 0;

  buddy_page_allocator u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall_o),
    .req_type_i    (req_type),
    .page_count_i  (page_count),
    .page_index_i  (page_index),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall),
    .status_o      (status_o),
    .alloc_index_o (alloc_index_o),
    .free_pages_o  (free_pages_o),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[buddy_page_allocator] ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 2);
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 2) == 0);
      default: out_stall <= ($urandom_range(0, 9) != 0);
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall) sb.check_result(status_o, alloc_index_o, free_pages_o);
  end

  task automatic send(bit r, logic [31:0] c, logic [14:0] i);
    answer_t a;
    in_valid <= 1'b1;
    req_type <= r;
    page_count <= c;
    page_index <= i;
    do @(posedge clk_i); while (in_stall_o);
    a = sb.note_request(r, c, i);
    items_sent++;
    if (r == 1'b0 && a.st == ST_OK) begin
      allocs_ok++;
      held_idx.push_back(int'(a.idx));
      held_cnt.push_back(int'(c));
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (sb.pending.size() != 0);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e r, logic [15:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= r;
    cfg_data <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(r, v);
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic setup(logic [15:0] tot, logic [14:0] base, logic [15:0] pages);
    drain();
    write_reg(CFG_TOTAL, tot);
    write_reg(CFG_BASE, {1'b0, base});
    write_reg(CFG_PAGES, pages);
    write_reg(CFG_UNUSED, 16'hFFFF);
    held_idx.delete();
    held_cnt.delete();
  endtask

  function automatic logic [31:0] rand_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return '0;
    if (r < 8) return $urandom();
    if (r < 14) return $urandom_range(1, 32768);
    return $urandom_range(1, 1 << $urandom_range(0, 5));
  endfunction

  task automatic run_random(int n, int base, int span);
    int burst;
    int k;
    int r;
    burst = $urandom_range(1, 30);
    repeat (n) begin
      if (burst == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
        burst = ($urandom_range(0, 4) == 0) ? 200 : $urandom_range(1, 30);
      end
      burst--;
      r = $urandom_range(0, 99);
      if (r < 45 || (r < 85 && held_idx.size() == 0)) begin
        send(1'b0, rand_count(), 15'($urandom()));
      end else if (r < 85) begin
        k = $urandom_range(0, held_idx.size() - 1);
        send(1'b1, 32'(held_cnt[k]), 15'(held_idx[k]));
        held_idx.delete(k);
        held_cnt.delete(k);
      end else if (r < 93) begin
        send(1'b1, rand_count(), 15'((base + $urandom_range(0, span)) % PAGE_CAP));
      end else begin
        send(1'b1, rand_count(), 15'($urandom()));
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send(1'b0, 32'd0, 15'd0);
    send(1'b1, 32'd0, 15'h7FFF);
    send(1'b0, 32'd32768, 15'd0);
    send(1'b0, 32'd1, 15'd0);
    send(1'b1, 32'd1, 15'd1);
    send(1'b1, 32'd1, 15'd3);
    send(1'b0, 32'd2, 15'd0);
    send(1'b1, 32'd1, 15'd3);
    send(1'b1, 32'd16384, 15'd16384);
    send(1'b1, 32'd32768, 15'd0);
    send(1'b1, 32'd16384, 15'd8192);
    send(1'b0, 32'd40000, 15'd0);
    send(1'b0, 32'hFFFF_FFFF, 15'd0);
    send(1'b1, 32'hFFFF_FFFF, 15'd0);
    send(1'b0, 32'd3, 15'd0);
    held_idx.delete();
    held_cnt.delete();

    setup(16'd64, 15'd0, 16'd64);
    run_random(300, 0, 63);
    setup(16'd32768, 15'h7FFF, 16'd2);
    run_random(120, 32766, 3);
    setup(16'd1, 15'd5, 16'd1);
    run_random(80, 0, 8);
    setup(16'd256, 15'd128, 16'd200);
    run_random(300, 128, 127);
    drain();
    run_random(150, 128, 127);
    setup(16'd32768, 15'd0, 16'd0);
    run_random(60, 0, 31);
    setup(16'd1024, 15'd37, 16'd32768);
    run_random(250, 0, 1023);
    setup(16'd1024, 15'd0, 16'd1024);
    run_random(350, 0, 1023);

    in_valid <= 1'b0;
    do @(posedge clk_i); while (sb.pending.size() != 0);
    repeat (100) @(posedge clk_i);
    $display("Sent %0d items over 8 register settings, %0d allocations granted, %0d results checked.",
             items_sent, allocs_ok, sb.checked);
    if (sb.errors == 0) begin
      $display("[buddy_page_allocator] OK");
    end else begin
      $display("%0d mismatches.", sb.errors);
      $display("[buddy_page_allocator] ERROR");
    end
    $finish;
  end
endmodule
